FILE: hw/rtl/fixed_window_rate_limiter_assert.svh
// Assertion macros for the rate limiter RTL, included by flr_back.
`ifndef FIXED_WINDOW_RATE_LIMITER_ASSERT_SVH
`define FIXED_WINDOW_RATE_LIMITER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define FLR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define FLR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/flr_pkg.sv
package flr_pkg;

  localparam int KEY_INDEX_W = 10;
  localparam int SCOPE_W     = 2;
  localparam int NOW_W       = 32;
  localparam int CNT_W       = 16;
  localparam int RETRY_W     = 16;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 16;
  localparam int KEY_W       = 16;  // holds any table index up to 65536 keys
  localparam int SCOPE_COUNT = 4;
  localparam int FIFO_DEPTH  = 2;

  localparam logic [CFG_DATA_W-1:0] RST_MAX_SCOPE0    = 16'd3;
  localparam logic [CFG_DATA_W-1:0] RST_WINDOW_SCOPE0 = 16'd3600;
  localparam logic [CFG_DATA_W-1:0] RST_MAX_SCOPE1    = 16'd10;
  localparam logic [CFG_DATA_W-1:0] RST_WINDOW_SCOPE1 = 16'd60;
  localparam logic [CFG_DATA_W-1:0] RST_MAX_SCOPE2    = 16'd5;
  localparam logic [CFG_DATA_W-1:0] RST_WINDOW_SCOPE2 = 16'd600;
  localparam logic [CFG_DATA_W-1:0] RST_MAX_SCOPE3    = 16'd10;
  localparam logic [CFG_DATA_W-1:0] RST_WINDOW_SCOPE3 = 16'd60;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_SCOPE0    = 4'd0,
    REG_WINDOW_SCOPE0 = 4'd1,
    REG_MAX_SCOPE1    = 4'd2,
    REG_WINDOW_SCOPE1 = 4'd3,
    REG_MAX_SCOPE2    = 4'd4,
    REG_WINDOW_SCOPE2 = 4'd5,
    REG_MAX_SCOPE3    = 4'd6,
    REG_WINDOW_SCOPE3 = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [NOW_W-1:0] now;
    logic [CNT_W-1:0] max_count;
    logic [NOW_W-1:0] new_win_end;
  } flr_req_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [NOW_W-1:0] win_end;
  } flr_entry_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_READ,
    ST_MODIFY
  } back_state_t;

endpackage

FILE: hw/rtl/fixed_window_rate_limiter.sv
// Fixed-window rate limiter over a table of KEY_COUNT client keys.
// Input channel (in_valid/in_ready): key index, scope 0..3, time in seconds.
// Output channel (out_valid/out_ready): one result per request, allowed flag
// and retry_after (seconds to window end, at least 1, on a deny; 0 on allow).
// Config channel (cfg_valid/cfg_ready, always ready): cfg_index 0..7 picks
// max and window per scope, pairs in scope order; other indexes are dropped.
// Write config only while no request is in flight.
// A request passes the input stage, FIFO, table read and result register.
// The back end serves one request at a time: the table's read then write
// of the key entry, through its single read and single write port.
// Reset: config returns to defaults, then the table is swept to zero, every
// key entry; in_ready stays low during the sweep.
// A stalled receiver holds the result register; two queued requests plus
// the input stage keep accepting until that backlog fills, then in_ready drops.
module fixed_window_rate_limiter import flr_pkg::*; #(
  parameter int KEY_COUNT = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [KEY_INDEX_W-1:0] in_key_index,
  input  logic [SCOPE_W-1:0]     in_scope,
  input  logic [NOW_W-1:0]       in_now_seconds,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_allowed,
  output logic [RETRY_W-1:0]     out_retry_after,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic     clearing;
  logic     push_valid;
  logic     push_ready;
  flr_req_t push_data;
  logic     pop_valid;
  logic     pop_ready;
  flr_req_t pop_data;

  flr_front #(
    .KEY_COUNT(KEY_COUNT)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_key_index  (in_key_index),
    .in_scope      (in_scope),
    .in_now_seconds(in_now_seconds),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .clearing      (clearing),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_data     (push_data)
  );

  flr_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  flr_back #(
    .KEY_COUNT(KEY_COUNT)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_data       (pop_data),
    .clearing       (clearing),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_allowed    (out_allowed),
    .out_retry_after(out_retry_after)
  );

endmodule

FILE: hw/rtl/flr_front.sv
module flr_front import flr_pkg::*; #(
  parameter int KEY_COUNT = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [KEY_INDEX_W-1:0] in_key_index,
  input  logic [SCOPE_W-1:0]     in_scope,
  input  logic [NOW_W-1:0]       in_now_seconds,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   clearing,
  output logic                   push_valid,
  input  logic                   push_ready,
  output flr_req_t               push_data
);

  localparam int KW = $clog2(KEY_COUNT);

  logic [CFG_DATA_W-1:0]  max_r    [SCOPE_COUNT];
  logic [CFG_DATA_W-1:0]  window_r [SCOPE_COUNT];
  logic                   s1_valid_r;
  logic                   s1_valid_nxt;
  logic [KEY_INDEX_W-1:0] s1_key_r;
  logic [SCOPE_W-1:0]     s1_scope_r;
  logic [NOW_W-1:0]       s1_now_r;
  logic                   load;
  logic [KW-1:0]          key_mod;
  logic [NOW_W:0]         end_sum;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r[0]    <= RST_MAX_SCOPE0;
      window_r[0] <= RST_WINDOW_SCOPE0;
      max_r[1]    <= RST_MAX_SCOPE1;
      window_r[1] <= RST_WINDOW_SCOPE1;
      max_r[2]    <= RST_MAX_SCOPE2;
      window_r[2] <= RST_WINDOW_SCOPE2;
      max_r[3]    <= RST_MAX_SCOPE3;
      window_r[3] <= RST_WINDOW_SCOPE3;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MAX_SCOPE0:    max_r[0]    <= cfg_data;
        REG_WINDOW_SCOPE0: window_r[0] <= cfg_data;
        REG_MAX_SCOPE1:    max_r[1]    <= cfg_data;
        REG_WINDOW_SCOPE1: window_r[1] <= cfg_data;
        REG_MAX_SCOPE2:    max_r[2]    <= cfg_data;
        REG_WINDOW_SCOPE2: window_r[2] <= cfg_data;
        REG_MAX_SCOPE3:    max_r[3]    <= cfg_data;
        REG_WINDOW_SCOPE3: window_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // no requests taken while the back end sweeps the table after reset
  assign in_ready = !clearing && (!s1_valid_r || push_ready);
  assign load     = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (load) begin
      s1_valid_nxt = 1'b1;
    end else if (push_ready) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_key_r   <= in_key_index;
      s1_scope_r <= in_scope;
      s1_now_r   <= in_now_seconds;
    end
  end

  generate
    if (KEY_COUNT < (1 << KEY_INDEX_W)) begin : g_mod
      // key mod KEY_COUNT by reciprocal multiply; exact for all 10-bit keys
      localparam int SH    = KEY_INDEX_W + KW;
      localparam int RECIP = ((1 << SH) + KEY_COUNT - 1) / KEY_COUNT;
      logic [KEY_INDEX_W+SH-1:0] prod;
      logic [KEY_INDEX_W-1:0]    quot_r;
      logic [2*KEY_INDEX_W-1:0]  back_prod;

      assign prod = (KEY_INDEX_W+SH)'(in_key_index) * (KEY_INDEX_W+SH)'(RECIP);

      always_ff @(posedge clk) begin
        if (load) begin
          quot_r <= KEY_INDEX_W'(prod >> SH);
        end
      end

      assign back_prod = (2*KEY_INDEX_W)'(quot_r) * (2*KEY_INDEX_W)'(KEY_COUNT);
      assign key_mod   = KW'(s1_key_r - back_prod[KEY_INDEX_W-1:0]);
    end else begin : g_pass
      assign key_mod = KW'(s1_key_r);
    end
  endgenerate

  assign end_sum = {1'b0, s1_now_r} + (NOW_W+1)'(window_r[s1_scope_r]);

  assign push_valid            = s1_valid_r;
  assign push_data.key         = KEY_W'(key_mod);
  assign push_data.now         = s1_now_r;
  assign push_data.max_count   = max_r[s1_scope_r];
  assign push_data.new_win_end = end_sum[NOW_W] ? '1 : end_sum[NOW_W-1:0];

endmodule

FILE: hw/rtl/flr_fifo.sv
module flr_fifo import flr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  flr_req_t push_data,
  output logic     pop_valid,
  input  logic     pop_ready,
  output flr_req_t pop_data
);

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  flr_req_t      slot_r [FIFO_DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] fill_r;
  logic [PW-1:0] wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_nxt;
  logic [CW-1:0] fill_nxt;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (fill_r != CW'(FIFO_DEPTH));
  assign pop_valid  = (fill_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: hw/rtl/flr_back.sv
module flr_back import flr_pkg::*; #(
  parameter int KEY_COUNT = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  flr_req_t           pop_data,
  output logic               clearing,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_allowed,
  output logic [RETRY_W-1:0] out_retry_after
);

`include "fixed_window_rate_limiter_assert.svh"

  localparam int KW = $clog2(KEY_COUNT);

  flr_entry_t         table_mem [KEY_COUNT];
  flr_entry_t         rdata_r;
  back_state_t        st_r;
  back_state_t        st_nxt;
  logic [KW-1:0]      clr_cnt_r;
  flr_req_t           req_r;
  logic               out_valid_r;
  logic               out_allowed_r;
  logic [RETRY_W-1:0] out_retry_after_r;
  logic               out_free;
  logic               rd_en;
  logic               mem_we;
  logic               out_load;
  logic [KW-1:0]      waddr;
  flr_entry_t         wdata;
  logic               expired;
  logic [CNT_W-1:0]   cur_count;
  logic [NOW_W-1:0]   cur_end;
  logic               deny;
  logic [NOW_W-1:0]   diff;
  logic [RETRY_W-1:0] retry;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_CLEAR:  if (clr_cnt_r == KW'(KEY_COUNT - 1)) st_nxt = ST_READ;
      ST_READ:   if (pop_valid) st_nxt = ST_MODIFY;
      ST_MODIFY: if (out_free) st_nxt = ST_READ;
      default:   st_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    clearing  = 1'b0;
    pop_ready = 1'b0;
    rd_en     = 1'b0;
    mem_we    = 1'b0;
    out_load  = 1'b0;
    case (st_r)
      ST_CLEAR: begin
        clearing = 1'b1;
        mem_we   = 1'b1;
      end
      ST_READ: begin
        pop_ready = 1'b1;
        rd_en     = pop_valid;
      end
      ST_MODIFY: begin
        mem_we   = out_free;
        out_load = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      req_r <= pop_data;
    end
  end

  // table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= table_mem[pop_data.key[KW-1:0]];
    end
  end

  // expired window restarts the count at zero
  assign expired   = (rdata_r.win_end <= req_r.now);
  assign cur_count = expired ? '0 : rdata_r.count;
  assign cur_end   = expired ? req_r.new_win_end : rdata_r.win_end;
  assign deny      = (cur_count >= req_r.max_count);
  assign diff      = cur_end - req_r.now;

  always_comb begin
    if (diff == '0) begin
      retry = RETRY_W'(1);
    end else if (|diff[NOW_W-1:RETRY_W]) begin
      retry = '1;
    end else begin
      retry = diff[RETRY_W-1:0];
    end
  end

  always_comb begin
    if (clearing) begin
      waddr = clr_cnt_r;
      wdata = '0;
    end else begin
      waddr         = req_r.key[KW-1:0];
      wdata.count   = deny ? cur_count : cur_count + 1'b1;
      wdata.win_end = cur_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_allowed_r     <= !deny;
      out_retry_after_r <= deny ? retry : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_allowed     = out_allowed_r;
  assign out_retry_after = out_retry_after_r;

  `FLR_ASSERT_NOW(a_no_result_in_clear, st_r == ST_CLEAR, !out_valid_r, "result during clear")
  `FLR_ASSERT_NEXT(a_load_shows_result, out_load, out_valid_r, "loaded result not shown")
  `FLR_ASSERT_NOW(a_allow_no_retry, out_valid_r && out_allowed_r, out_retry_after_r == '0, "allowed with retry")
  `FLR_ASSERT_NOW(a_deny_has_retry, out_valid_r && !out_allowed_r, out_retry_after_r != '0, "denied without retry")
  `FLR_ASSERT_NOW(a_no_pop_in_modify, st_r == ST_MODIFY, !pop_ready, "pop while entry in flight")

endmodule
